// ----- rtl/spq_pkg.sv -----
// ============================================================================
// Sorted priority queue package
// Shared codes and the control group that the queue hands to every cell.
// ============================================================================
package spq_pkg;

    // Request codes carried in the action field.
    typedef enum logic {
        ACT_ENQUEUE = 1'b0,
        ACT_DEQUEUE = 1'b1
    } action_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Operation applied by every cell in the same cycle.
    typedef struct packed {
        logic enq;
        logic deq;
    } cell_op_t;

endpackage

// ----- rtl/spq_req_if.sv -----
// ============================================================================
// Sorted priority queue request channel
// Valid/ready channel that carries one enqueue or dequeue request.
// ============================================================================
interface spq_req_if #(
    parameter int TAG_BITS  = 16,
    parameter int PRIO_BITS = 8
);
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [TAG_BITS-1:0]  task_tag;
    logic [PRIO_BITS-1:0] priority_req;

    modport source (output valid, action, task_tag, priority_req, input ready);
    modport sink   (input valid, action, task_tag, priority_req, output ready);
endinterface

// ----- rtl/spq_rsp_if.sv -----
// ============================================================================
// Sorted priority queue response channel
// Valid/ready channel that carries the result of one request.
// ============================================================================
interface spq_rsp_if #(
    parameter int TAG_BITS  = 16,
    parameter int PRIO_BITS = 8,
    parameter int CNT_W     = 9
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [TAG_BITS-1:0]  out_tag;
    logic [PRIO_BITS-1:0] out_priority;
    logic [CNT_W-1:0]     occupancy;

    modport source (output valid, status, out_tag, out_priority, occupancy, input ready);
    modport sink   (input valid, status, out_tag, out_priority, occupancy, output ready);
endinterface

// ----- rtl/spq_cell.sv -----
// ============================================================================
// Sorted priority queue cell
// Holds one entry. On an enqueue it keeps its entry, takes the new one or
// takes its left neighbour's; on a dequeue it takes its right neighbour's.
// ============================================================================
module spq_cell
    import spq_pkg::*;
#(
    parameter int TAG_BITS  = 16,
    parameter int PRIO_BITS = 8
) (
    input  logic                 clk,
    input  cell_op_t             op,
    input  logic                 occupied,
    input  logic [TAG_BITS-1:0]  new_tag,
    input  logic [PRIO_BITS-1:0] new_prio,
    input  logic                 left_gt,
    input  logic [TAG_BITS-1:0]  left_tag,
    input  logic [PRIO_BITS-1:0] left_prio,
    input  logic [TAG_BITS-1:0]  right_tag,
    input  logic [PRIO_BITS-1:0] right_prio,
    output logic                 gt,
    output logic [TAG_BITS-1:0]  tag,
    output logic [PRIO_BITS-1:0] prio
);

    logic [TAG_BITS-1:0]  tag_reg;
    logic [TAG_BITS-1:0]  tag_next;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [PRIO_BITS-1:0] prio_next;
    logic                 insert_here;

    // The held entry must move back when its priority is strictly above the new one.
    assign gt = occupied && (prio_reg > new_prio);

    // The new entry lands in the first cell that is either behind it or empty.
    assign insert_here = !left_gt && (gt || !occupied);

    // Select the next entry for this cell.
    always_comb
    begin
        tag_next  = tag_reg;
        prio_next = prio_reg;
        if (op.deq)
        begin
            tag_next  = right_tag;
            prio_next = right_prio;
        end
        else if (op.enq)
        begin
            if (left_gt)
            begin
                tag_next  = left_tag;
                prio_next = left_prio;
            end
            else if (insert_here)
            begin
                tag_next  = new_tag;
                prio_next = new_prio;
            end
        end
    end

    // Entry storage; payload only, so no reset.
    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
    end

    assign tag  = tag_reg;
    assign prio = prio_reg;

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// ============================================================================
// Sorted priority queue
// Bounded queue of tagged entries kept in ascending priority order in a row
// of cells; the smallest priority leaves first, ties in arrival order.
// ============================================================================
// Usage:
// Requests arrive on the req channel: action 0 enqueues task_tag with
// priority_req, action 1 dequeues the head entry. Each request transaction
// produces exactly one response transaction on rsp, carrying the status
// (ok, full or empty), the dequeued tag and priority (zero otherwise) and
// the occupancy after the request.
// The response is registered at the edge that takes the request. Every
// cell compares, shifts or loads in parallel, so one request is taken in
// every cycle; the single output register sets that figure. While a
// response waits, a new request is still taken in the cycle the response
// is taken; if rsp stalls, req.ready stays low.
// Reset clears the occupancy count and the response valid; the cell
// contents are undefined until written and are never read before that.
// ============================================================================
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int TAG_BITS  = 16,
    parameter int PRIO_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    status_t              status_reg;
    status_t              status_next;
    logic [TAG_BITS-1:0]  out_tag_reg;
    logic [TAG_BITS-1:0]  out_tag_next;
    logic [PRIO_BITS-1:0] out_prio_reg;
    logic [PRIO_BITS-1:0] out_prio_next;

    logic                 take;
    logic                 is_full;
    logic                 is_empty;
    cell_op_t             op;

    logic                 cell_gt   [DEPTH];
    logic                 cell_occ  [DEPTH];
    logic [TAG_BITS-1:0]  cell_tag  [DEPTH];
    logic [PRIO_BITS-1:0] cell_prio [DEPTH];

    // Handshake: take a request whenever the output register is free or drains.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign take      = req.valid && req.ready;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Operation broadcast to the cells.
    always_comb
    begin
        op.enq = take && (action_t'(req.action) == ACT_ENQUEUE) && !is_full;
        op.deq = take && (action_t'(req.action) == ACT_DEQUEUE) && !is_empty;
    end

    // Row of cells.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                 left_gt;
        logic [TAG_BITS-1:0]  left_tag;
        logic [PRIO_BITS-1:0] left_prio;
        logic [TAG_BITS-1:0]  right_tag;
        logic [PRIO_BITS-1:0] right_prio;

        assign cell_occ[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_gt   = 1'b0;
            assign left_tag  = cell_tag[i];
            assign left_prio = cell_prio[i];
        end
        else
        begin : g_inner_left
            assign left_gt   = cell_gt[i-1];
            assign left_tag  = cell_tag[i-1];
            assign left_prio = cell_prio[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_tag  = cell_tag[i];
            assign right_prio = cell_prio[i];
        end
        else
        begin : g_inner_right
            assign right_tag  = cell_tag[i+1];
            assign right_prio = cell_prio[i+1];
        end

        spq_cell #(
            .TAG_BITS  (TAG_BITS),
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .clk        (clk),
            .op         (op),
            .occupied   (cell_occ[i]),
            .new_tag    (req.task_tag),
            .new_prio   (req.priority_req),
            .left_gt    (left_gt),
            .left_tag   (left_tag),
            .left_prio  (left_prio),
            .right_tag  (right_tag),
            .right_prio (right_prio),
            .gt         (cell_gt[i]),
            .tag        (cell_tag[i]),
            .prio       (cell_prio[i])
        );
    end

    // Occupancy and response for the request taken in this cycle.
    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        out_tag_next   = out_tag_reg;
        out_prio_next  = out_prio_reg;
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (take)
        begin
            rsp_valid_next = 1'b1;
            status_next    = ST_OK;
            out_tag_next   = '0;
            out_prio_next  = '0;
            if (action_t'(req.action) == ACT_ENQUEUE)
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next    = count_reg - CNT_W'(1);
                    out_tag_next  = cell_tag[0];
                    out_prio_next = cell_prio[0];
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        out_tag_reg  <= out_tag_next;
        out_prio_reg <= out_prio_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_tag      = out_tag_reg;
    assign rsp.out_priority = out_prio_reg;
    assign rsp.occupancy    = count_reg;

endmodule
